### rtl/uf_pkg.sv
// Package for the union-find unit: action codes, field widths and the
// control group passed from the sequencer to the parent table.
// Depends on nothing.
`timescale 1ns / 1ps

package uf_pkg;

  localparam int MAX_VAR_DEF = 64;
  localparam int FIELD_W     = 7;
  localparam int ACT_W       = 2;

  localparam logic [ACT_W-1:0] ACT_FIND  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UNION = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } tbl_ctrl_t;

endpackage

### rtl/uf_table.sv
// Parent table of the union-find unit: a single-port-read, single-port-write
// memory with a registered read and one valid bit per entry.
// Depends on uf_pkg.
`timescale 1ns / 1ps

module uf_table
  import uf_pkg::*;
#(
  parameter int MAX_VAR = MAX_VAR_DEF,
  localparam int DEPTH  = MAX_VAR + 1,
  localparam int IDX_W  = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tbl_ctrl_t        ctrl,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] wr_data,
  output logic [IDX_W-1:0] rdata
);

  logic [IDX_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [IDX_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_vld_r;

  // An entry that has never been written since reset or a clear points at itself.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctrl.clr) begin
      valid_r <= '0;
    end else if (ctrl.wr) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= valid_r[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : rd_idx_r;

endmodule

### rtl/uf_seq.sv
// Sequencer of the union-find unit: handles both handshakes, walks each
// variable to its root, compresses the path and links roots on a union.
// Depends on uf_pkg; drives uf_table through a tbl_ctrl_t group.
`timescale 1ns / 1ps

module uf_seq
  import uf_pkg::*;
#(
  parameter int MAX_VAR = MAX_VAR_DEF,
  localparam int DEPTH  = MAX_VAR + 1,
  localparam int IDX_W  = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [FIELD_W-1:0] in_first_var,
  input  logic [FIELD_W-1:0] in_second_var,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_same_set,
  output logic [FIELD_W-1:0] out_root_first,
  output logic [FIELD_W-1:0] out_root_second,
  output tbl_ctrl_t          ctrl,
  output logic [IDX_W-1:0]   rd_addr,
  output logic [IDX_W-1:0]   wr_addr,
  output logic [IDX_W-1:0]   wr_data,
  input  logic [IDX_W-1:0]   rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_COMP,
    S_LINK,
    S_DONE
  } state_t;

  localparam logic [31:0] MAX_U = 32'(MAX_VAR);

  state_t             state_r, state_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic [IDX_W-1:0]   y_r, y_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [IDX_W-1:0]   start_r, start_nxt;
  logic [IDX_W-1:0]   root_r, root_nxt;
  logic [IDX_W-1:0]   rx_r, rx_nxt;
  logic               which_r, which_nxt;
  logic               res_same_r, res_same_nxt;
  logic [FIELD_W-1:0] res_rf_r, res_rf_nxt;
  logic [FIELD_W-1:0] res_rs_r, res_rs_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_same_r, out_same_nxt;
  logic [FIELD_W-1:0] out_rf_r, out_rf_nxt;
  logic [FIELD_W-1:0] out_rs_r, out_rs_nxt;
  logic               fin;
  logic [IDX_W-1:0]   fin_root;
  logic               x_ok;
  logic               y_ok;

  assign x_ok = ({{(32 - FIELD_W){1'b0}}, in_first_var} <= MAX_U);
  assign y_ok = ({{(32 - FIELD_W){1'b0}}, in_second_var} <= MAX_U);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    y_nxt         = y_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    root_nxt      = root_r;
    rx_nxt        = rx_r;
    which_nxt     = which_r;
    res_same_nxt  = res_same_r;
    res_rf_nxt    = res_rf_r;
    res_rs_nxt    = res_rs_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_same_nxt  = out_same_r;
    out_rf_nxt    = out_rf_r;
    out_rs_nxt    = out_rs_r;
    ctrl          = '0;
    rd_addr       = cur_r;
    wr_addr       = cur_r;
    wr_data       = root_r;
    fin           = 1'b0;
    fin_root      = root_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt      = in_action;
          cur_nxt      = IDX_W'(in_first_var);
          start_nxt    = IDX_W'(in_first_var);
          y_nxt        = IDX_W'(in_second_var);
          which_nxt    = 1'b0;
          res_same_nxt = 1'b0;
          res_rf_nxt   = '0;
          res_rs_nxt   = '0;
          if (in_action == ACT_CLEAR) begin
            ctrl.clr  = 1'b1;
            state_nxt = S_DONE;
          end else if ((in_action != ACT_FIND && in_action != ACT_UNION) ||
                       !x_ok || !y_ok) begin
            state_nxt = S_DONE;
          end else if (in_action == ACT_FIND && in_first_var == in_second_var) begin
            res_same_nxt = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        ctrl.rd   = 1'b1;
        rd_addr   = cur_r;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (rdata == cur_r) begin
          root_nxt = cur_r;
          if (start_r == cur_r) begin
            fin      = 1'b1;
            fin_root = cur_r;
          end else begin
            ctrl.rd   = 1'b1;
            rd_addr   = start_r;
            cur_nxt   = start_r;
            state_nxt = S_COMP;
          end
        end else begin
          ctrl.rd = 1'b1;
          rd_addr = rdata;
          cur_nxt = rdata;
        end
      end
      S_COMP: begin
        ctrl.wr = 1'b1;
        wr_addr = cur_r;
        wr_data = root_r;
        if (rdata == root_r) begin
          fin      = 1'b1;
          fin_root = root_r;
        end else begin
          ctrl.rd = 1'b1;
          rd_addr = rdata;
          cur_nxt = rdata;
        end
      end
      S_LINK: begin
        ctrl.wr   = 1'b1;
        wr_addr   = rx_r;
        wr_data   = root_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_same_nxt  = res_same_r;
          out_rf_nxt    = res_rf_r;
          out_rs_nxt    = res_rs_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The first find hands over to the second; the second settles the result.
    if (fin) begin
      if (!which_r) begin
        rx_nxt    = fin_root;
        cur_nxt   = y_r;
        start_nxt = y_r;
        which_nxt = 1'b1;
        state_nxt = S_START;
      end else begin
        res_same_nxt = (rx_r == fin_root);
        res_rf_nxt   = FIELD_W'(rx_r);
        res_rs_nxt   = FIELD_W'(fin_root);
        if (act_r == ACT_UNION && rx_r != fin_root) begin
          state_nxt = S_LINK;
        end else begin
          state_nxt = S_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      act_r       <= act_nxt;
      y_r         <= y_nxt;
      cur_r       <= cur_nxt;
      start_r     <= start_nxt;
      root_r      <= root_nxt;
      rx_r        <= rx_nxt;
      which_r     <= which_nxt;
      res_same_r  <= res_same_nxt;
      res_rf_r    <= res_rf_nxt;
      res_rs_r    <= res_rs_nxt;
      out_same_r  <= out_same_nxt;
      out_rf_r    <= out_rf_nxt;
      out_rs_r    <= out_rs_nxt;
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_same_set    = out_same_r;
  assign out_root_first  = out_rf_r;
  assign out_root_second = out_rs_r;

endmodule

### rtl/union_find_path_compression_unit.sv
// Clear, unused or out-of-range actions and a find on equal variables go from acceptance
// straight to the result slot; otherwise both variables are walked to their roots with their
// paths compressed, and a linking union adds one write of the parent table.
// The unit works on one item at a time; the next item is taken in the cycle its result appears,
// whether or not that result has been taken yet.
// Reset (synchronous, rst_n low) empties the output slot and marks every entry as its own root.
`timescale 1ns / 1ps

module union_find_path_compression_unit
  import uf_pkg::*;
#(
  parameter int MAX_VAR = MAX_VAR_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [FIELD_W-1:0] in_first_var,
  input  logic [FIELD_W-1:0] in_second_var,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_same_set,
  output logic [FIELD_W-1:0] out_root_first,
  output logic [FIELD_W-1:0] out_root_second
);

  localparam int IDX_W = $clog2(MAX_VAR + 1);

  tbl_ctrl_t        ctrl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] wr_data;
  logic [IDX_W-1:0] rdata;

  uf_seq #(
    .MAX_VAR(MAX_VAR)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_first_var   (in_first_var),
    .in_second_var  (in_second_var),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_same_set   (out_same_set),
    .out_root_first (out_root_first),
    .out_root_second(out_root_second),
    .ctrl           (ctrl),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rdata          (rdata)
  );

  uf_table #(
    .MAX_VAR(MAX_VAR)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rdata  (rdata)
  );

endmodule

### rtl/uf_checker.sv
// Port-level checker for the union-find unit, attached by a bind statement.
// Depends on uf_pkg and on the ports of union_find_path_compression_unit.
`timescale 1ns / 1ps

module uf_checker
  import uf_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [ACT_W-1:0]   in_action,
  input logic [FIELD_W-1:0] in_first_var,
  input logic [FIELD_W-1:0] in_second_var,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_same_set,
  input logic [FIELD_W-1:0] out_root_first,
  input logic [FIELD_W-1:0] out_root_second
);

  // The block works on one item at a time, so it drops ready after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an item was accepted");

  // Reset leaves the output slot empty.
  a_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high straight after reset");

  // Two different roots can never be reported as the same set.
  a_roots_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_root_first != out_root_second) |-> !out_same_set)
    else $error("same_set reported with differing roots");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_same_set) &&
      $stable(out_root_first) && $stable(out_root_second))
    else $error("result item changed while stalled");

endmodule

bind union_find_path_compression_unit uf_checker u_uf_checker (.*);
